/* rtl/ssa_pkg.sv */
// shared types and constants for the swap slot allocator
`default_nettype none

package ssa_pkg;

   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam int KIND_W   = 1;
   localparam int SIDX_W   = 10;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SECTOR_W = 13;
   localparam int CNT_W    = 11;
   localparam int RESULT_CAP = 8;

   localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

   localparam logic [KIND_W-1:0] KIND_SWAP_OUT = 1'b0;
   localparam logic [KIND_W-1:0] KIND_SWAP_IN  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_SETUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             hit;
      logic [BIT_W-1:0] bit_idx;
   } scan_result_type;

endpackage

`default_nettype wire

/* rtl/ssa_word_unit.sv */
// bitmap word unit: finds the lowest free bit or checks one bit, and builds the updated word
`default_nettype none

module ssa_word_unit (
   input  wire logic [ssa_pkg::WORD_W-1:0] word,
   input  wire logic [ssa_pkg::WORD_W-1:0] mask,
   input  wire logic                       claim,
   input  wire logic [ssa_pkg::BIT_W-1:0]  bit_sel,
   output ssa_pkg::scan_result_type        result,
   output logic [ssa_pkg::WORD_W-1:0]      new_word
);

   logic [ssa_pkg::WORD_W-1:0] free_bits;
   logic [ssa_pkg::BIT_W-1:0]  low_idx;
   logic [ssa_pkg::WORD_W-1:0] onehot;

   always_comb begin
      free_bits = ~word & mask;
      low_idx   = '0;
      for (int i = ssa_pkg::WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            low_idx = ssa_pkg::BIT_W'(i);
         end
      end
      if (claim) begin
         result.hit     = |free_bits;
         result.bit_idx = low_idx;
      end else begin
         result.hit     = word[bit_sel];
         result.bit_idx = bit_sel;
      end
      onehot = ssa_pkg::WORD_W'(1) << result.bit_idx;
      if (claim) begin
         new_word = word | onehot;
      end else begin
         new_word = word & ~onehot;
      end
   end

endmodule

`default_nettype wire

/* rtl/swap_slot_allocator.sv */
// swap slot allocator top level: bitmap memory, sequencer and sector command output
`default_nettype none

// Keeps one used bit per swap slot in a memory of 32-bit words with one read port and
// one write port. After reset a clearing pass zeroes the bitmap, one word per cycle; no
// transaction is taken on req_ until it ends, csr_ writes are taken at any time. One item
// is worked at a time. A swap-out reads the bitmap word by word from slot 0, each word in
// a fetch state and then a check state, up to the last word that holds a slot below the
// slot count (at most MAX_SLOTS), and stops at the first free slot; then come a setup
// state and the sector commands (eight by default), one per cycle while rsp_ready is high.
// A swap-in reads the one word that holds its slot and, if that slot is used, goes on the
// same way. The rate is set by the single read port of the bitmap and by the sector
// commands, which are issued one at a time.
module swap_slot_allocator #(
   parameter int MAX_SLOTS        = 1024,
   parameter int SECTORS_PER_PAGE = 8,
   parameter int SECTOR_BYTES     = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ssa_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [ssa_pkg::SIDX_W-1:0]       req_slot_index,
   input  wire logic [ssa_pkg::ADDR_W-1:0]       req_page_address,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ssa_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                  rsp_is_write,
   output logic [ssa_pkg::SECTOR_W-1:0]          rsp_sector,
   output logic [ssa_pkg::ADDR_W-1:0]            rsp_memory_address,
   output logic [ssa_pkg::SIDX_W-1:0]            rsp_slot,
   output logic                                  rsp_last,

   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ssa_pkg::CNT_W-1:0]        csr_slot_count
);

   localparam int ROWS      = (MAX_SLOTS + ssa_pkg::WORD_W - 1) / ssa_pkg::WORD_W;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_CNT_W = $clog2(ROWS + 1);
   localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int LIM_W     = ($clog2(MAX_SLOTS + 1) > ssa_pkg::CNT_W) ?
                              $clog2(MAX_SLOTS + 1) : ssa_pkg::CNT_W;
   localparam int NUM_CMDS  = (SECTORS_PER_PAGE > ssa_pkg::RESULT_CAP) ?
                              ssa_pkg::RESULT_CAP : SECTORS_PER_PAGE;
   localparam int STEP_W    = (NUM_CMDS > 1) ? $clog2(NUM_CMDS) : 1;

   ssa_pkg::state_type state_ff, state_in;

   logic [ssa_pkg::CNT_W-1:0]    slot_count_ff;
   logic [ROW_W-1:0]             clr_ff, clr_in;
   logic [ROW_CNT_W-1:0]         row_ff, row_in;
   logic [ssa_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [ssa_pkg::SIDX_W-1:0]   sidx_ff, sidx_in;
   logic [ssa_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [SLOT_W-1:0]            hit_slot_ff, hit_slot_in;
   logic [ssa_pkg::SIDX_W-1:0]   slot_ff, slot_in;
   logic [ssa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ssa_pkg::SECTOR_W-1:0] sector_ff, sector_in;
   logic [ssa_pkg::ADDR_W-1:0]   maddr_ff, maddr_in;
   logic [STEP_W-1:0]            step_ff, step_in;

   logic [ssa_pkg::WORD_W-1:0]   bitmap_mem [ROWS];
   logic [ssa_pkg::WORD_W-1:0]   rd_word_ff;
   logic                         mem_we;
   logic [ROW_W-1:0]             mem_waddr;
   logic [ssa_pkg::WORD_W-1:0]   mem_wdata;
   logic [ROW_W-1:0]             mem_raddr;

   logic [LIM_W-1:0]             limit;
   logic [LIM_W-1:0]             lim_row;
   logic [ssa_pkg::BIT_W-1:0]    lim_bits;
   logic [ssa_pkg::WORD_W-1:0]   scan_mask;
   logic                         scan_done;
   logic                         req_fire;
   logic                         rsp_fire;
   logic                         sidx_in_range;
   logic                         clr_done;
   logic                         claim;
   logic [ssa_pkg::WORD_W-1:0]   new_word;
   ssa_pkg::scan_result_type     scan_res;

   // bitmap word unit
   ssa_word_unit u_word_unit (
      .word     (rd_word_ff),
      .mask     (scan_mask),
      .claim    (claim),
      .bit_sel  (sidx_ff[ssa_pkg::BIT_W-1:0]),
      .result   (scan_res),
      .new_word (new_word)
   );

   assign claim     = (kind_ff == ssa_pkg::KIND_SWAP_OUT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;
   assign clr_done  = (clr_ff == ROW_W'(ROWS - 1));
   assign sidx_in_range = (32'(req_slot_index) < 32'(MAX_SLOTS));

   // allocation bound
   always_comb begin
      if (32'(slot_count_ff) > 32'(MAX_SLOTS)) begin
         limit = LIM_W'(MAX_SLOTS);
      end else begin
         limit = LIM_W'(slot_count_ff);
      end
      lim_row  = limit >> ssa_pkg::BIT_W;
      lim_bits = limit[ssa_pkg::BIT_W-1:0];
      scan_done = (32'(row_ff) > 32'(lim_row)) ||
                  ((32'(row_ff) == 32'(lim_row)) && (lim_bits == '0));
      if (!claim) begin
         scan_mask = '1;
      end else if (32'(row_ff) < 32'(lim_row)) begin
         scan_mask = '1;
      end else begin
         scan_mask = (ssa_pkg::WORD_W'(1) << lim_bits) - ssa_pkg::WORD_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssa_pkg::ST_CLEAR: begin
            if (clr_done) begin
               state_in = ssa_pkg::ST_IDLE;
            end
         end
         ssa_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == ssa_pkg::KIND_SWAP_IN && !sidx_in_range) begin
                  state_in = ssa_pkg::ST_EMIT;
               end else begin
                  state_in = ssa_pkg::ST_FETCH;
               end
            end
         end
         ssa_pkg::ST_FETCH: begin
            if (claim && scan_done) begin
               state_in = ssa_pkg::ST_EMIT;
            end else begin
               state_in = ssa_pkg::ST_CHECK;
            end
         end
         ssa_pkg::ST_CHECK: begin
            if (scan_res.hit) begin
               state_in = ssa_pkg::ST_SETUP;
            end else if (claim) begin
               state_in = ssa_pkg::ST_FETCH;
            end else begin
               state_in = ssa_pkg::ST_EMIT;
            end
         end
         ssa_pkg::ST_SETUP: begin
            state_in = ssa_pkg::ST_EMIT;
         end
         ssa_pkg::ST_EMIT: begin
            if (rsp_fire && rsp_last) begin
               state_in = ssa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssa_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_in      = clr_ff;
      row_in      = row_ff;
      kind_in     = kind_ff;
      sidx_in     = sidx_ff;
      addr_in     = addr_ff;
      hit_slot_in = hit_slot_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      sector_in   = sector_ff;
      maddr_in    = maddr_ff;
      step_in     = step_ff;
      mem_we      = 1'b0;
      mem_waddr   = row_ff[ROW_W-1:0];
      mem_wdata   = new_word;
      mem_raddr   = row_ff[ROW_W-1:0];
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ssa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ROW_W'(1);
         end
         ssa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               kind_in  = req_kind;
               sidx_in  = req_slot_index;
               addr_in  = req_page_address;
               step_in  = '0;
               if (req_kind == ssa_pkg::KIND_SWAP_OUT) begin
                  row_in = '0;
               end else begin
                  row_in = ROW_CNT_W'(req_slot_index >> ssa_pkg::BIT_W);
               end
               if (req_kind == ssa_pkg::KIND_SWAP_IN && !sidx_in_range) begin
                  status_in = ssa_pkg::STATUS_NOT_USED;
                  slot_in   = req_slot_index;
                  sector_in = '0;
                  maddr_in  = '0;
               end
            end
         end
         ssa_pkg::ST_FETCH: begin
            if (claim && scan_done) begin
               status_in = ssa_pkg::STATUS_NO_SLOT;
               slot_in   = '0;
               sector_in = '0;
               maddr_in  = '0;
            end
         end
         ssa_pkg::ST_CHECK: begin
            if (scan_res.hit) begin
               mem_we = 1'b1;
               if (claim) begin
                  hit_slot_in = SLOT_W'({row_ff, scan_res.bit_idx});
                  slot_in     = ssa_pkg::SIDX_W'({row_ff, scan_res.bit_idx});
               end else begin
                  hit_slot_in = SLOT_W'(sidx_ff);
                  slot_in     = sidx_ff;
               end
               status_in = ssa_pkg::STATUS_OK;
            end else if (claim) begin
               row_in = row_ff + ROW_CNT_W'(1);
            end else begin
               status_in = ssa_pkg::STATUS_NOT_USED;
               slot_in   = sidx_ff;
               sector_in = '0;
               maddr_in  = '0;
            end
         end
         ssa_pkg::ST_SETUP: begin
            sector_in = ssa_pkg::SECTOR_W'(32'(hit_slot_ff) * 32'(SECTORS_PER_PAGE));
            maddr_in  = addr_ff;
         end
         ssa_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_fire) begin
               step_in   = step_ff + STEP_W'(1);
               sector_in = sector_ff + ssa_pkg::SECTOR_W'(1);
               maddr_in  = maddr_ff + ssa_pkg::ADDR_W'(SECTOR_BYTES);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_status         = status_ff;
   assign rsp_is_write       = claim;
   assign rsp_sector         = sector_ff;
   assign rsp_memory_address = maddr_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_last           = (status_ff != ssa_pkg::STATUS_OK) ||
                               (step_ff == STEP_W'(NUM_CMDS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ssa_pkg::ST_CLEAR;
         clr_ff        <= '0;
         slot_count_ff <= ssa_pkg::SLOT_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_valid && csr_ready) begin
            slot_count_ff <= csr_slot_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      kind_ff     <= kind_in;
      sidx_ff     <= sidx_in;
      addr_ff     <= addr_in;
      hit_slot_ff <= hit_slot_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      sector_ff   <= sector_in;
      maddr_ff    <= maddr_in;
      step_ff     <= step_in;
   end

   // bitmap memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= bitmap_mem[mem_raddr];
   end

`ifndef SYNTHESIS
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ssa_pkg::STATUS_OK |-> rsp_last)
      else $error("error result not flagged last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("accepted a second transaction while busy");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("not idle after final result");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(step_ff) < 32'(NUM_CMDS))
      else $error("sector step beyond command count");
`endif

endmodule

`default_nettype wire
